// ===== rtl/mph_pkg.sv =====
// ----------------------------------------------------------------------------
// mph_pkg
// Shared types, constants and helpers of the mesh path hash appender.
// ----------------------------------------------------------------------------
package mph_pkg;

    localparam int LEN_WIDTH  = 10;
    localparam int SPAN_W     = LEN_WIDTH + 1;
    localparam int PREFIX_W   = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int GRP_SLOTS  = 4;
    localparam int GRP_CNT_W  = 3;
    localparam int POS_W      = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PACKET_LEN        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_KEY_PREFIX        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPORT_FLOOD_CODE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPORT_DIRECT_CODE = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_BAD_LENGTH   = 3'd1;
    localparam logic [2:0] ST_HEADER_SHORT = 3'd2;
    localparam logic [2:0] ST_PATH_OVERRUN = 3'd3;
    localparam logic [2:0] ST_BAD_HASH     = 3'd4;
    localparam logic [2:0] ST_PATH_FULL    = 3'd5;
    localparam logic [2:0] ST_NO_ROOM      = 3'd6;

    // path-length byte position
    localparam logic [POS_W-1:0] PLP_PLAIN     = 3'd1;
    localparam logic [POS_W-1:0] PLP_TRANSPORT = 3'd5;

    localparam logic [5:0] HASH_COUNT_FULL = 6'h3F;
    localparam logic [2:0] HASH_SIZE_MAX   = 3'd3;

    typedef struct packed {
        logic [LEN_WIDTH-1:0] max_packet_len;
        logic [PREFIX_W-1:0]  own_key_prefix;
        logic [1:0]           transport_flood_code;
        logic [1:0]           transport_direct_code;
    } mph_cfg_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic [2:0] status;
    } mph_result_t;

    typedef struct packed {
        mph_result_t [GRP_SLOTS-1:0] slot;
        logic [GRP_CNT_W-1:0]        count;
    } mph_group_t;

    function automatic logic [7:0] prefix_byte(input logic [PREFIX_W-1:0] prefix,
                                               input logic [1:0] k);
        logic [7:0] b;
        unique case (k)
            2'd0:    b = prefix[23:16];
            2'd1:    b = prefix[15:8];
            default: b = prefix[7:0];
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/mph_if.sv =====
// ----------------------------------------------------------------------------
// mph_if
// Valid/ready channel interfaces for packet input, result output and config.
// ----------------------------------------------------------------------------
interface mph_in_if;
    logic                          valid;
    logic                          ready;
    logic [7:0]                    data_byte;
    logic [mph_pkg::LEN_WIDTH-1:0] pkt_length;
    logic                          in_last;

    modport source (output valid, data_byte, pkt_length, in_last, input ready);
    modport sink   (input valid, data_byte, pkt_length, in_last, output ready);
endinterface

interface mph_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic [2:0] status;

    modport source (output valid, out_byte, out_last, status, input ready);
    modport sink   (input valid, out_byte, out_last, status, output ready);
endinterface

interface mph_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mph_pkg::CFG_IDX_W-1:0] index;
    logic [mph_pkg::PREFIX_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/mesh_path_hash_appender.sv =====
// ----------------------------------------------------------------------------
// mesh_path_hash_appender
// Streaming relay packet rewriter that appends the own key prefix to the path.
// ----------------------------------------------------------------------------
// usage:
//   in_stream  - one packet byte per transaction with the packet length and a
//                last flag; bytes come header first
//   out_stream - output bytes; status is meaningful on the out_last byte
//   cfg        - register writes (index, data); always ready, write only while
//                no packet byte is in flight
// flow: a byte accepted on in_stream is registered in the input register, parsed
//   into the result holder when it takes a group, and shows on out_stream from there
// throughput: one byte per cycle on pass-through bytes while out_stream is ready;
//   the byte at the insert point (or the last byte when the insert falls at the
//   packet end) yields hash size plus one output transactions, and the next byte
//   waits in the input register while the result holder hands them out
// stall: when out_stream is not ready, the result holder keeps its bytes, the
//   input register fills and in_stream.ready drops; nothing is lost
// reset: rst_n clears all pending transactions, parser position state and the
//   config registers to their defaults; no clearing pass is needed
// ----------------------------------------------------------------------------
module mesh_path_hash_appender
(
    input  logic      clk,
    input  logic      rst_n,
    mph_in_if.sink    in_stream,
    mph_out_if.source out_stream,
    mph_cfg_if.sink   cfg
);
    import mph_pkg::*;

    mph_cfg_t   cfg_q;       // live register values
    mph_group_t grp;         // results caused by the parsed byte
    logic       grp_valid;
    logic       grp_ready;

    // config register file
    mph_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_q)
    );

    // input register, route / path checks and result group build
    mph_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_stream (in_stream),
        .cfg       (cfg_q),
        .grp       (grp),
        .grp_valid (grp_valid),
        .grp_ready (grp_ready)
    );

    // result holder, serializes inserted prefix bytes
    mph_out_queue u_out_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .grp        (grp),
        .grp_valid  (grp_valid),
        .grp_ready  (grp_ready),
        .out_stream (out_stream)
    );

endmodule

// ===== rtl/mph_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mph_cfg_regs
// Configuration register file written through the config channel.
// ----------------------------------------------------------------------------
module mph_cfg_regs
(
    input  logic              clk,
    input  logic              rst_n,
    mph_cfg_if.sink           cfg,
    output mph_pkg::mph_cfg_t cfg_out
);
    import mph_pkg::*;

    mph_cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_out   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_packet_len        <= LEN_WIDTH'(255);
            cfg_reg.own_key_prefix        <= '0;
            cfg_reg.transport_flood_code  <= 2'd0;
            cfg_reg.transport_direct_code <= 2'd3;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_MAX_PACKET_LEN:
                    cfg_reg.max_packet_len <= cfg.data[LEN_WIDTH-1:0];
                REG_OWN_KEY_PREFIX:
                    cfg_reg.own_key_prefix <= cfg.data;
                REG_TRANSPORT_FLOOD_CODE:
                    cfg_reg.transport_flood_code <= cfg.data[1:0];
                REG_TRANSPORT_DIRECT_CODE:
                    cfg_reg.transport_direct_code <= cfg.data[1:0];
                default:
                    cfg_reg.transport_direct_code <= cfg_reg.transport_direct_code;
            endcase
        end
    end

endmodule

// ===== rtl/mph_parser.sv =====
// ----------------------------------------------------------------------------
// mph_parser
// Input register, packet position state and per-byte result group builder.
// ----------------------------------------------------------------------------
module mph_parser
(
    input  logic               clk,
    input  logic               rst_n,
    mph_in_if.sink             in_stream,
    input  mph_pkg::mph_cfg_t  cfg,
    output mph_pkg::mph_group_t grp,
    output logic               grp_valid,
    input  logic               grp_ready
);
    import mph_pkg::*;

    logic                 in_valid_reg;
    logic [7:0]           byte_reg;
    logic [LEN_WIDTH-1:0] size_reg;
    logic                 last_reg;

    logic [LEN_WIDTH-1:0] byte_position_reg,     byte_position_next;
    logic [POS_W-1:0]     path_len_position_reg, path_len_position_next;
    logic [LEN_WIDTH-1:0] insert_position_reg,   insert_position_next;
    logic [1:0]           hash_size_reg,         hash_size_next;
    logic                 insert_enable_reg,     insert_enable_next;
    logic [2:0]           result_code_reg,       result_code_next;

    logic                 fire;
    logic [2:0]           hs_raw;
    logic [5:0]           cnt;
    logic [SPAN_W-1:0]    span;
    logic [7:0]           ob;
    logic [2:0]           st;
    logic                 ins_pre;
    logic                 ins_end;
    logic [1:0]           route;
    logic [2:0]           hs_ext;

    assign fire            = in_valid_reg && grp_ready;
    assign grp_valid       = in_valid_reg;
    assign in_stream.ready = !in_valid_reg || grp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_stream.ready)
        begin
            in_valid_reg <= in_stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_stream.ready && in_stream.valid)
        begin
            byte_reg <= in_stream.data_byte;
            size_reg <= in_stream.pkt_length;
            last_reg <= in_stream.in_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg     <= '0;
            path_len_position_reg <= PLP_PLAIN;
            insert_position_reg   <= '0;
            hash_size_reg         <= 2'd1;
            insert_enable_reg     <= 1'b0;
            result_code_reg       <= ST_OK;
        end
        else if (fire)
        begin
            byte_position_reg     <= byte_position_next;
            path_len_position_reg <= path_len_position_next;
            insert_position_reg   <= insert_position_next;
            hash_size_reg         <= hash_size_next;
            insert_enable_reg     <= insert_enable_next;
            result_code_reg       <= result_code_next;
        end
    end

    // header and path-length checks, state update
    always_comb
    begin
        byte_position_next     = byte_position_reg;
        path_len_position_next = path_len_position_reg;
        insert_position_next   = insert_position_reg;
        hash_size_next         = hash_size_reg;
        insert_enable_next     = insert_enable_reg;
        result_code_next       = result_code_reg;
        ob                     = byte_reg;
        ins_pre                = 1'b0;
        st                     = ST_OK;
        route                  = byte_reg[1:0];
        hs_raw                 = {1'b0, byte_reg[7:6]} + 3'd1;
        cnt                    = byte_reg[5:0];
        span                   = SPAN_W'(path_len_position_reg) + SPAN_W'(1)
                                 + SPAN_W'(hs_raw) * SPAN_W'(cnt);

        if (byte_position_reg == '0)
        begin
            result_code_next   = ST_OK;
            insert_enable_next = 1'b0;
            path_len_position_next = (route == cfg.transport_flood_code ||
                                      route == cfg.transport_direct_code)
                                     ? PLP_TRANSPORT : PLP_PLAIN;
            if (size_reg < LEN_WIDTH'(2) || size_reg > cfg.max_packet_len)
                result_code_next = ST_BAD_LENGTH;
            else if (LEN_WIDTH'(path_len_position_next) >= size_reg)
                result_code_next = ST_HEADER_SHORT;
        end
        else if (byte_position_reg == LEN_WIDTH'(path_len_position_reg) &&
                 result_code_reg == ST_OK && !insert_enable_reg)
        begin
            if (span > {1'b0, size_reg})
                result_code_next = ST_PATH_OVERRUN;
            else if (hs_raw > HASH_SIZE_MAX)
                result_code_next = ST_BAD_HASH;
            else if (cnt == HASH_COUNT_FULL)
                result_code_next = ST_PATH_FULL;
            else if ({1'b0, size_reg} + SPAN_W'(hs_raw) > {1'b0, cfg.max_packet_len})
                result_code_next = ST_NO_ROOM;
            else
            begin
                insert_enable_next   = 1'b1;
                insert_position_next = span[LEN_WIDTH-1:0];
                hash_size_next       = hs_raw[1:0];
                ob                   = {byte_reg[7:6], cnt + 6'd1};
            end
        end
        else if (insert_enable_reg && byte_position_reg == insert_position_reg)
        begin
            ins_pre            = 1'b1;
            insert_enable_next = 1'b0;
        end

        ins_end = last_reg && insert_enable_next;

        if (last_reg)
        begin
            if (result_code_next != ST_OK)
                st = result_code_next;
            else if (byte_position_reg < LEN_WIDTH'(path_len_position_next))
                st = ST_HEADER_SHORT;
            else if (insert_enable_next &&
                     (byte_position_reg + LEN_WIDTH'(1)) != insert_position_next)
                st = ST_PATH_OVERRUN;
            else
                st = ST_OK;
            insert_enable_next = 1'b0;
            byte_position_next = '0;
        end
        else
        begin
            byte_position_next = byte_position_reg + LEN_WIDTH'(1);
        end
    end

    // result group: prefix bytes before or after the current byte
    always_comb
    begin
        hs_ext = {1'b0, hash_size_next};
        for (int j = 0; j < GRP_SLOTS; j++)
        begin
            grp.slot[j] = '0;
            if (ins_pre)
            begin
                if (3'(j) < hs_ext)
                    grp.slot[j].out_byte = prefix_byte(cfg.own_key_prefix, 2'(j));
                else if (3'(j) == hs_ext)
                begin
                    grp.slot[j].out_byte = ob;
                    grp.slot[j].out_last = last_reg;
                    grp.slot[j].status   = st;
                end
            end
            else if (ins_end)
            begin
                if (j == 0)
                    grp.slot[j].out_byte = ob;
                else if (3'(j) <= hs_ext)
                begin
                    grp.slot[j].out_byte = prefix_byte(cfg.own_key_prefix, 2'(j - 1));
                    grp.slot[j].out_last = (3'(j) == hs_ext);
                    grp.slot[j].status   = (3'(j) == hs_ext) ? st : ST_OK;
                end
            end
            else if (j == 0)
            begin
                grp.slot[j].out_byte = ob;
                grp.slot[j].out_last = last_reg;
                grp.slot[j].status   = st;
            end
        end
        grp.count = (ins_pre || ins_end) ? hs_ext + 3'd1 : 3'd1;
    end

    a_code_blocks_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (result_code_reg != ST_OK) |-> !insert_enable_reg)
        else $error("insert armed while a check has failed");

    a_hash_size_legal: assert property (@(posedge clk) disable iff (!rst_n)
        insert_enable_reg |-> (hash_size_reg != 2'd0))
        else $error("insert armed with zero hash size");

endmodule

// ===== rtl/mph_out_queue.sv =====
// ----------------------------------------------------------------------------
// mph_out_queue
// Holds one result group and hands its bytes out one transaction at a time.
// ----------------------------------------------------------------------------
module mph_out_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  mph_pkg::mph_group_t grp,
    input  logic                grp_valid,
    output logic                grp_ready,
    mph_out_if.source           out_stream
);
    import mph_pkg::*;

    mph_result_t [GRP_SLOTS-1:0] slot_reg;
    logic [GRP_CNT_W-1:0]        count_reg;
    logic [GRP_CNT_W-1:0]        rd_reg;
    logic [GRP_CNT_W-1:0]        remaining;
    logic                        pop;
    logic                        load;
    mph_result_t                 head;

    assign remaining = count_reg - rd_reg;
    assign pop       = out_stream.valid && out_stream.ready;
    assign grp_ready = (remaining == '0) || (remaining == GRP_CNT_W'(1) && out_stream.ready);
    assign load      = grp_valid && grp_ready;
    assign head      = slot_reg[rd_reg[1:0]];

    assign out_stream.valid    = (remaining != '0);
    assign out_stream.out_byte = head.out_byte;
    assign out_stream.out_last = head.out_last;
    assign out_stream.status   = head.status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rd_reg    <= '0;
        end
        else if (load)
        begin
            count_reg <= grp.count;
            rd_reg    <= '0;
        end
        else if (pop)
        begin
            rd_reg <= rd_reg + GRP_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg <= grp.slot;
        end
    end

    a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_reg <= count_reg) && (count_reg <= GRP_CNT_W'(GRP_SLOTS)))
        else $error("read pointer past group end");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (remaining == '0 || (remaining == GRP_CNT_W'(1) && pop)))
        else $error("group loaded over pending results");

endmodule
